FILE: hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication or plain property, checked on every clock outside reset.
`define MRSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MRSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mrsd_pkg.sv
// Types and constants of the match record stream decoder.
// No dependencies; used by the interface instances and the top level.
package mrsd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic [31:0] target_pos;
    logic [31:0] source_pos;
    logic [31:0] match_length;
    logic [3:0]  status;
  } rec_item_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_COMPLETE = 4'd1;
  localparam logic [3:0] ST_HEADER   = 4'd2;
  localparam logic [3:0] ST_OVERFLOW = 4'd3;
  localparam logic [3:0] ST_TRUNC    = 4'd4;
  localparam logic [3:0] ST_MODE     = 4'd5;
  localparam logic [3:0] ST_SHIFT    = 4'd6;
  localparam logic [3:0] ST_RANGE    = 4'd7;
  localparam logic [3:0] ST_TRAILING = 4'd8;

  localparam logic [7:0] MAGIC_BYTES [0:7] = '{
    8'h48, 8'h46, 8'h43, 8'h43, 8'h31, 8'h00, 8'h00, 8'h00
  };

  // LEB128: ten bytes at most, the tenth may not continue.
  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  localparam logic [3:0] HEADER_LAST_IDX = 4'd15;
  localparam logic [7:0] MODE_NEW        = 8'd0;
  localparam logic [7:0] MODE_SAME       = 8'd1;
  localparam logic [7:0] MODE_DELTA      = 8'd2;

endpackage

FILE: hdl/mrsd_stream_if.sv
// Valid/ready stream channel carrying one word of a given payload type.
// Payload types come from mrsd_pkg at the point of instantiation.
interface mrsd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/match_record_stream_decoder.sv
// Match record stream decoder: one input word (byte) per clock while the skid entry is empty.
// A result is written into the output register by the edge that accepts its word when
// the output register is free or taken that cycle; otherwise it waits in the skid entry.
// The cycle is set by the single-pass decode path: varint shift-or, 64-bit add and compares.
// A two-entry output buffer lets input continue while one result waits to be taken.
// Reset (rst_n low, synchronous) clears the decode state and the output valid flags; the decoder then expects a header.
module match_record_stream_decoder (
  input logic           clk,
  input logic           rst_n,
  mrsd_stream_if.sink   in_stream,
  mrsd_stream_if.source out_stream
);
  import mrsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_GAP, PH_MODE, PH_DIST, PH_LEN, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [63:0] expected_r, expected_nxt;
  logic [63:0] done_r, done_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [63:0] pgap_r, pgap_nxt;
  logic [1:0]  pmode_r, pmode_nxt;
  logic [63:0] ldist_r, ldist_nxt;
  logic [32:0] pend_r, pend_nxt;
  logic        dropping_r, dropping_nxt;

  rec_item_t   out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r, res_valid;

  logic        in_ready, in_fire, pop, push, main_free;
  logic [7:0]  b;
  logic        last;

  // Combinational decode signals.
  logic        do_fail, do_start;
  logic [3:0]  fail_code;
  logic [5:0]  shamt;
  logic [63:0] take_acc;
  logic        take_done, take_ovf;
  logic [3:0]  vcnt_step;
  logic [63:0] mag, mag1, hdr_full, done_inc;
  logic [64:0] sum65;
  logic [63:0] sum_sat;
  logic [33:0] tsum;
  logic [31:0] target;

  // Output word checks.
  logic        out_is_err, out_is_rec, out_fields_zero, out_status_rec, out_src_ok;

  assign in_ready        = !skid_valid_r;
  assign in_stream.ready = in_ready;
  assign in_fire         = in_stream.valid && in_ready;
  assign b               = in_stream.payload.data_byte;
  assign last            = in_stream.payload.last_byte;

  // Shift of the current varint byte: seven bits per byte already taken.
  assign shamt     = 6'({2'b00, vcnt_r, 3'b000} - {5'b00000, vcnt_r});
  assign take_acc  = accum_r | (64'(b[6:0]) << shamt);
  assign take_done = !b[7];
  assign take_ovf  = b[7] && (vcnt_r == VARINT_LAST_IDX);
  // The byte count only grows while the varint goes on.
  assign vcnt_step = (take_done || take_ovf) ? 4'd0 : vcnt_r + 4'd1;

  assign mag      = {1'b0, take_acc[63:1]};
  assign mag1     = mag + 64'd1;
  assign sum65    = {1'b0, ldist_r} + {1'b0, mag};
  assign sum_sat  = sum65[64] ? {64{1'b1}} : sum65[63:0];
  assign tsum     = {1'b0, pend_r} + {2'b00, pgap_r[31:0]};
  assign target   = tsum[31:0];
  assign done_inc = done_r + 64'd1;
  assign hdr_full = expected_r | (64'(b) << {hidx_r[2:0], 3'b000});

  always_comb begin
    phase_nxt    = phase_r;
    hidx_nxt     = hidx_r;
    expected_nxt = expected_r;
    done_nxt     = done_r;
    accum_nxt    = accum_r;
    vcnt_nxt     = vcnt_r;
    pgap_nxt     = pgap_r;
    pmode_nxt    = pmode_r;
    ldist_nxt    = ldist_r;
    pend_nxt     = pend_r;
    dropping_nxt = dropping_r;
    res          = '0;
    res_valid    = 1'b0;
    do_fail      = 1'b0;
    do_start     = 1'b0;
    fail_code    = ST_OK;

    if (dropping_r) begin
      if (last) begin
        dropping_nxt = 1'b0;
        do_start     = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_HEADER: begin
          if (!hidx_r[3] && (b != MAGIC_BYTES[hidx_r[2:0]])) begin
            do_fail   = 1'b1;
            fail_code = ST_HEADER;
          end else begin
            if (hidx_r[3]) begin
              expected_nxt = hdr_full;
            end
            hidx_nxt = hidx_r + 4'd1;
            if (hidx_r != HEADER_LAST_IDX) begin
              if (last) begin
                do_fail   = 1'b1;
                fail_code = ST_HEADER;
              end
            end else begin
              done_nxt  = '0;
              accum_nxt = '0;
              vcnt_nxt  = '0;
              if (hdr_full == 64'd0) begin
                if (last) begin
                  res_valid  = 1'b1;
                  res.status = ST_COMPLETE;
                  do_start   = 1'b1;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                phase_nxt = PH_GAP;
                if (last) begin
                  do_fail   = 1'b1;
                  fail_code = ST_TRUNC;
                end
              end
            end
          end
        end

        PH_GAP: begin
          accum_nxt = take_acc;
          vcnt_nxt  = vcnt_step;
          if (take_ovf) begin
            do_fail   = 1'b1;
            fail_code = ST_OVERFLOW;
          end else begin
            if (take_done) begin
              pgap_nxt  = take_acc;
              phase_nxt = PH_MODE;
            end
            if (last) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNC;
            end
          end
        end

        PH_MODE: begin
          if (b > MODE_DELTA) begin
            do_fail   = 1'b1;
            fail_code = ST_MODE;
          end else begin
            pmode_nxt = b[1:0];
            phase_nxt = (b == MODE_SAME) ? PH_LEN : PH_DIST;
            accum_nxt = '0;
            vcnt_nxt  = '0;
            if (last) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNC;
            end
          end
        end

        PH_DIST: begin
          accum_nxt = take_acc;
          vcnt_nxt  = vcnt_step;
          if (take_ovf) begin
            do_fail   = 1'b1;
            fail_code = ST_OVERFLOW;
          end else if (take_done && (pmode_r == MODE_DELTA[1:0]) && take_acc[0]
                       && (ldist_r <= mag1)) begin
            do_fail   = 1'b1;
            fail_code = ST_SHIFT;
          end else if (take_done && (pmode_r == MODE_DELTA[1:0]) && !take_acc[0]
                       && (sum_sat == 64'd0)) begin
            do_fail   = 1'b1;
            fail_code = ST_SHIFT;
          end else begin
            if (take_done) begin
              if (pmode_r == MODE_NEW[1:0]) begin
                ldist_nxt = take_acc;
              end else if (take_acc[0]) begin
                ldist_nxt = ldist_r - mag1;
              end else begin
                ldist_nxt = sum_sat;
              end
              phase_nxt = PH_LEN;
              accum_nxt = '0;
              vcnt_nxt  = '0;
            end
            if (last) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNC;
            end
          end
        end

        PH_LEN: begin
          accum_nxt = take_acc;
          vcnt_nxt  = vcnt_step;
          if (take_ovf) begin
            do_fail   = 1'b1;
            fail_code = ST_OVERFLOW;
          end else if (!take_done) begin
            if (last) begin
              do_fail   = 1'b1;
              fail_code = ST_TRUNC;
            end
          end else if ((pgap_r[63:32] != 32'd0) || (tsum[33:32] != 2'b00)
                       || (take_acc[63:32] != 32'd0)
                       || (ldist_r > {32'd0, target})) begin
            do_fail   = 1'b1;
            fail_code = ST_RANGE;
          end else begin
            pend_nxt         = {1'b0, target} + {1'b0, take_acc[31:0]};
            done_nxt         = done_inc;
            res_valid        = 1'b1;
            res.record_valid = 1'b1;
            res.target_pos   = target;
            res.source_pos   = target - ldist_r[31:0];
            res.match_length = take_acc[31:0];
            if (done_inc == expected_r) begin
              res.status = last ? ST_COMPLETE : ST_OK;
              phase_nxt  = PH_DONE;
            end else begin
              res.status = last ? ST_TRUNC : ST_OK;
              phase_nxt  = PH_GAP;
              accum_nxt  = '0;
              vcnt_nxt   = '0;
            end
            do_start = last;
          end
        end

        default: begin
          do_fail   = 1'b1;
          fail_code = ST_TRAILING;
        end
      endcase
    end

    // An error reports zero fields; recovery depends on the end mark.
    if (do_fail) begin
      res_valid  = 1'b1;
      res        = '0;
      res.status = fail_code;
      if (last) begin
        do_start = 1'b1;
      end else begin
        dropping_nxt = 1'b1;
      end
    end

    if (do_start) begin
      phase_nxt    = PH_HEADER;
      hidx_nxt     = '0;
      expected_nxt = '0;
      done_nxt     = '0;
      accum_nxt    = '0;
      vcnt_nxt     = '0;
      pgap_nxt     = '0;
      pmode_nxt    = '0;
      ldist_nxt    = '0;
      pend_nxt     = '0;
    end
  end

  assign pop       = out_valid_r && out_stream.ready;
  assign push      = in_fire && res_valid;
  assign main_free = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hidx_r       <= '0;
      expected_r   <= '0;
      done_r       <= '0;
      accum_r      <= '0;
      vcnt_r       <= '0;
      pgap_r       <= '0;
      pmode_r      <= '0;
      ldist_r      <= '0;
      pend_r       <= '0;
      dropping_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        hidx_r     <= hidx_nxt;
        expected_r <= expected_nxt;
        done_r     <= done_nxt;
        accum_r    <= accum_nxt;
        vcnt_r     <= vcnt_nxt;
        pgap_r     <= pgap_nxt;
        pmode_r    <= pmode_nxt;
        ldist_r    <= ldist_nxt;
        pend_r     <= pend_nxt;
        dropping_r <= dropping_nxt;
      end
      // Input is held off while the skid entry is full, so no push then.
      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (main_free) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_stream.valid   = out_valid_r;
  assign out_stream.payload = out_r;

  assign out_is_err      = out_valid_r && !out_r.record_valid;
  assign out_is_rec      = out_valid_r && out_r.record_valid;
  assign out_fields_zero = (out_r.target_pos == 32'd0) && (out_r.source_pos == 32'd0)
                           && (out_r.match_length == 32'd0);
  assign out_status_rec  = (out_r.status == ST_OK) || (out_r.status == ST_COMPLETE)
                           || (out_r.status == ST_TRUNC);
  assign out_src_ok      = out_r.source_pos <= out_r.target_pos;

`include "assert_macros.svh"

  `MRSD_ASSERT(a_skid_behind_main, skid_valid_r |-> out_valid_r, "skid full, output empty")
  `MRSD_ASSERT_NEXT(a_skid_refill, skid_valid_r && pop, out_valid_r && !skid_valid_r, "skid stuck")
  `MRSD_ASSERT(a_error_zero, out_is_err |-> out_fields_zero, "error word with nonzero fields")
  `MRSD_ASSERT(a_record_status, out_is_rec |-> out_status_rec, "record word with error status")
  `MRSD_ASSERT(a_source_le_target, out_is_rec |-> out_src_ok, "source beyond target")
  `MRSD_ASSERT(a_varint_bound, vcnt_r <= VARINT_LAST_IDX, "varint byte count beyond ten bytes")

endmodule

FILE: verif/mrsd_check_pkg.sv
// Scoreboard for the match record stream decoder testbench: a bit-exact predictor
// of the decoder and the queue of records it is expected to emit.
// Depends on mrsd_pkg for the word types, status codes, modes and the magic bytes.
package mrsd_check_pkg;
  import mrsd_pkg::*;

  typedef enum logic [2:0] {AT_HEADER, AT_GAP, AT_MODE, AT_DIST, AT_LEN, AT_END} parse_step_t;
  typedef enum int {VARINT_MORE, VARINT_DONE, VARINT_OVERFLOW} varint_state_t;

  localparam logic [63:0] LIMIT32 = 64'hFFFF_FFFF;

  class match_record_scoreboard;
    parse_step_t step;
    int unsigned hdr_idx;
    int unsigned shift;
    logic [63:0] rec_count;
    logic [63:0] rec_seen;
    logic [63:0] accum;
    logic [63:0] gap;
    logic [63:0] last_dist;
    logic [63:0] end_pos;
    logic [7:0]  mode;
    bit          skipping;
    rec_item_t   expected_q[$];
    int          failures;

    function new();
      skipping = 1'b0;
      failures = 0;
      restart();
    endfunction

    // A new header clears the counts, the last distance and the running end.
    function void restart();
      step = AT_HEADER;
      hdr_idx = 0;
      shift = 0;
      rec_count = '0;
      rec_seen = '0;
      accum = '0;
      gap = '0;
      last_dist = '0;
      end_pos = '0;
      mode = MODE_NEW;
    endfunction

    function void expect_record(logic v, logic [63:0] t, logic [63:0] s, logic [63:0] l,
                                logic [3:0] code);
      rec_item_t r;
      r.record_valid = v;
      r.target_pos = t[31:0];
      r.source_pos = s[31:0];
      r.match_length = l[31:0];
      r.status = code;
      expected_q = {expected_q, r};
    endfunction

    // Errors carry no record. Unless the error falls on the final word, the rest
    // of the stream is skipped up to its end mark.
    function void flag_error(logic [3:0] code, bit fin);
      expect_record(1'b0, '0, '0, '0, code);
      if (fin) begin
        skipping = 1'b0;
        restart();
      end else begin
        skipping = 1'b1;
      end
    endfunction

    function varint_state_t take_varint(logic [7:0] b);
      if (shift < 64) accum |= {57'd0, b[6:0]} << shift;
      if (!b[7]) return VARINT_DONE;
      shift += 7;
      return (shift >= 64) ? VARINT_OVERFLOW : VARINT_MORE;
    endfunction

    function void note_word(in_item_t w);
      logic [7:0]    b;
      bit            fin;
      varint_state_t vs;
      logic [63:0]   v;
      logic [63:0]   mag;
      logic [63:0]   target;
      logic [63:0]   len;
      logic [64:0]   sum;
      logic [3:0]    code;
      b = w.data_byte;
      fin = w.last_byte;
      if (skipping) begin
        if (fin) begin
          skipping = 1'b0;
          restart();
        end
        return;
      end
      case (step)
        AT_HEADER: begin
          if (hdr_idx < 8) begin
            if (b != MAGIC_BYTES[hdr_idx]) begin
              flag_error(ST_HEADER, fin);
              return;
            end
          end else begin
            rec_count |= {56'd0, b} << (8 * (hdr_idx - 8));
          end
          hdr_idx++;
          if (hdr_idx < 16) begin
            if (fin) flag_error(ST_HEADER, 1'b1);
            return;
          end
          rec_seen = '0;
          accum = '0;
          shift = 0;
          if (rec_count == 0) begin
            if (fin) begin
              expect_record(1'b0, '0, '0, '0, ST_COMPLETE);
              restart();
            end else begin
              step = AT_END;
            end
          end else begin
            step = AT_GAP;
            if (fin) flag_error(ST_TRUNC, 1'b1);
          end
        end
        AT_GAP: begin
          vs = take_varint(b);
          if (vs == VARINT_OVERFLOW) begin
            flag_error(ST_OVERFLOW, fin);
            return;
          end
          if (vs == VARINT_DONE) begin
            gap = accum;
            step = AT_MODE;
          end
          if (fin) flag_error(ST_TRUNC, 1'b1);
        end
        AT_MODE: begin
          if (b > MODE_DELTA) begin
            flag_error(ST_MODE, fin);
            return;
          end
          mode = b;
          step = (b == MODE_SAME) ? AT_LEN : AT_DIST;
          accum = '0;
          shift = 0;
          if (fin) flag_error(ST_TRUNC, 1'b1);
        end
        AT_DIST: begin
          vs = take_varint(b);
          if (vs == VARINT_OVERFLOW) begin
            flag_error(ST_OVERFLOW, fin);
            return;
          end
          if (vs == VARINT_DONE) begin
            v = accum;
            if (mode == MODE_NEW) begin
              last_dist = v;
            end else begin
              // Zigzag: odd codes are negative deltas of -(v/2 + 1).
              mag = v >> 1;
              if (v[0]) begin
                if (last_dist <= mag + 64'd1) begin
                  flag_error(ST_SHIFT, fin);
                  return;
                end
                last_dist = last_dist - (mag + 64'd1);
              end else begin
                sum = {1'b0, last_dist} + {1'b0, mag};
                if (sum[64]) sum[63:0] = '1;
                if (sum[63:0] == 0) begin
                  flag_error(ST_SHIFT, fin);
                  return;
                end
                last_dist = sum[63:0];
              end
            end
            step = AT_LEN;
            accum = '0;
            shift = 0;
          end
          if (fin) flag_error(ST_TRUNC, 1'b1);
        end
        AT_LEN: begin
          vs = take_varint(b);
          if (vs == VARINT_OVERFLOW) begin
            flag_error(ST_OVERFLOW, fin);
            return;
          end
          if (vs == VARINT_MORE) begin
            if (fin) flag_error(ST_TRUNC, 1'b1);
            return;
          end
          len = accum;
          if (gap > LIMIT32 || end_pos + gap > LIMIT32 || len > LIMIT32) begin
            flag_error(ST_RANGE, fin);
            return;
          end
          target = end_pos + gap;
          if (last_dist > target) begin
            flag_error(ST_RANGE, fin);
            return;
          end
          end_pos = target + len;
          rec_seen++;
          if (rec_seen == rec_count) begin
            code = fin ? ST_COMPLETE : ST_OK;
            step = AT_END;
          end else begin
            code = fin ? ST_TRUNC : ST_OK;
            step = AT_GAP;
            accum = '0;
            shift = 0;
          end
          expect_record(1'b1, target, target - last_dist, len, code);
          if (fin) restart();
        end
        default: begin
          flag_error(ST_TRAILING, fin);
        end
      endcase
    endfunction

    function void check_record(rec_item_t got);
      rec_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected record: status %0d, target_pos %0d", got.status, got.target_pos);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.record_valid !== want.record_valid) begin
        $error("record_valid: expected %0d, actual %0d", want.record_valid, got.record_valid);
        failures++;
      end
      if (got.target_pos !== want.target_pos) begin
        $error("target_pos: expected %0d, actual %0d", want.target_pos, got.target_pos);
        failures++;
      end
      if (got.source_pos !== want.source_pos) begin
        $error("source_pos: expected %0d, actual %0d", want.source_pos, got.source_pos);
        failures++;
      end
      if (got.match_length !== want.match_length) begin
        $error("match_length: expected %0d, actual %0d", want.match_length, got.match_length);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

FILE: verif/tb.sv
// Top-level testbench of match_record_stream_decoder: directed streams, then random
// well-formed and damaged streams, with random stalls on both channels.
// Depends on mrsd_pkg, mrsd_stream_if and the scoreboard in mrsd_check_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrsd_pkg::*;
  import mrsd_check_pkg::*;

  typedef enum int {
    FAULT_NONE, FAULT_CUT, FAULT_TAIL, FAULT_MAGIC, FAULT_MODE,
    FAULT_OVERFLOW, FAULT_SHIFT, FAULT_RANGE, FAULT_COUNT, FAULT_NOISE
  } fault_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   words_sent;
  int   stall_left;

  logic [7:0]  frame_q[$];
  logic [63:0] gen_end;
  logic [63:0] gen_dist;

  match_record_scoreboard sb;

  mrsd_stream_if #(.payload_t(in_item_t))  in_stream ();
  mrsd_stream_if #(.payload_t(rec_item_t)) out_stream ();

  match_record_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_stream.valid && in_stream.ready) sb.note_word(in_stream.payload);
    if (rst_n && out_stream.valid && out_stream.ready) sb.check_record(out_stream.payload);
  end

  // Result side: ready drops at random, in bursts.
  initial begin
    out_stream.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stream.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stream.ready <= 1'b0;
      end else begin
        out_stream.ready <= 1'b1;
      end
    end
  end

  function automatic int pad_choice();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  function automatic void add_byte(logic [7:0] v);
    frame_q = {frame_q, v};
  endfunction

  // LEB128, optionally padded with extra continuation words up to ten.
  // A tenth word keeps only bit 63, so its upper bits are filled at random.
  function automatic void put_leb(logic [63:0] v, int pad);
    int n;
    int k;
    logic [7:0] b;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    n = (n + pad > 10) ? 10 : n + pad;
    for (k = 0; k < n; k++) begin
      b = {1'b0, 7'(v >> (7 * k))};
      if (k == 9) b[6:1] = 6'($urandom);
      b[7] = (k < n - 1);
      add_byte(b);
    end
  endfunction

  function automatic void put_header(logic [63:0] count);
    int k;
    for (k = 0; k < 8; k++) add_byte(MAGIC_BYTES[k]);
    for (k = 0; k < 8; k++) add_byte(count[8*k +: 8]);
    gen_end = '0;
    gen_dist = '0;
  endfunction

  function automatic void put_record(logic [63:0] gap, logic [7:0] mode, logic [63:0] dval,
                                     logic [63:0] len);
    put_leb(gap, pad_choice());
    add_byte(mode);
    if (mode != MODE_SAME) put_leb(dval, pad_choice());
    put_leb(len, pad_choice());
  endfunction

  function automatic logic [63:0] zigzag(longint delta);
    return (delta >= 0) ? (64'(delta) << 1) : ((64'(-delta) << 1) - 64'd1);
  endfunction

  // A record that mostly decodes cleanly; the fault, if any, spoils it on purpose.
  function automatic void put_random_record(fault_t fault);
    logic [63:0] gap;
    logic [63:0] len;
    logic [63:0] target;
    logic [63:0] t32;
    logic [63:0] newd;
    logic [63:0] code;
    logic [7:0]  mode;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) gap = $urandom_range(0, 200);
    else if (pick < 9) gap = $urandom_range(0, 1 << 20);
    else gap = (gen_end < LIMIT32) ? $urandom_range(0, 32'(LIMIT32 - gen_end)) : '0;
    pick = $urandom_range(0, 9);
    if (pick < 7) len = $urandom_range(0, 300);
    else if (pick < 9) len = $urandom_range(0, 1 << 20);
    else len = $urandom;
    target = gen_end + gap;
    t32 = (target > LIMIT32) ? LIMIT32 : target;
    case ($urandom_range(0, 2))
      0: mode = MODE_NEW;
      1: mode = MODE_SAME;
      default: mode = MODE_DELTA;
    endcase
    code = '0;
    case (mode)
      MODE_NEW: begin
        newd = $urandom_range(0, 32'(t32));
        code = newd;
      end
      MODE_SAME: begin
        newd = gen_dist;
      end
      default: begin
        newd = $urandom_range(1, (t32 == 0) ? 1 : 32'(t32));
        code = zigzag(longint'(newd) - longint'(gen_dist));
      end
    endcase
    if (fault == FAULT_OVERFLOW) begin
      if ($urandom_range(0, 1)) begin
        put_leb(gap, 0);
        add_byte(MODE_SAME);
      end
      repeat (10) add_byte(8'h80 | 8'($urandom));
      return;
    end
    if (fault == FAULT_MODE) mode = 8'($urandom_range(MODE_DELTA + 1, 255));
    if (fault == FAULT_SHIFT) begin
      mode = MODE_DELTA;
      code = zigzag(-longint'(gen_dist) - longint'($urandom_range(0, 3)));
    end
    if (fault == FAULT_RANGE) begin
      case ($urandom_range(0, 3))
        0: gap = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
        1: len = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
        2: begin
          mode = MODE_NEW;
          code = target + 64'd1 + $urandom_range(0, 9);
        end
        default: gap = (gen_end <= LIMIT32) ? LIMIT32 - gen_end + 64'd1 : gap;
      endcase
    end
    put_record(gap, mode, code, len);
    gen_end = target + len;
    gen_dist = newd;
  endfunction

  function automatic void build_random_frame();
    fault_t      f;
    int          pick;
    int          n;
    int          bad_at;
    int          k;
    int          cut;
    logic [63:0] declared;
    pick = $urandom_range(0, 99);
    if (pick < 55) f = FAULT_NONE;
    else if (pick < 62) f = FAULT_CUT;
    else if (pick < 68) f = FAULT_TAIL;
    else if (pick < 73) f = FAULT_MAGIC;
    else if (pick < 78) f = FAULT_MODE;
    else if (pick < 83) f = FAULT_OVERFLOW;
    else if (pick < 88) f = FAULT_SHIFT;
    else if (pick < 93) f = FAULT_RANGE;
    else if (pick < 97) f = FAULT_COUNT;
    else f = FAULT_NOISE;
    if (f == FAULT_NOISE) begin
      repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
      return;
    end
    n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
    if (n == 0 && (f == FAULT_MODE || f == FAULT_OVERFLOW || f == FAULT_SHIFT ||
                   f == FAULT_RANGE)) n = 1;
    declared = n;
    if (f == FAULT_COUNT) begin
      declared = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : n + $urandom_range(1, 3);
    end
    put_header(declared);
    if (f == FAULT_MAGIC) frame_q[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    bad_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (k = 0; k < n; k++) put_random_record((k == bad_at) ? f : FAULT_NONE);
    if (f == FAULT_TAIL) repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    if (f == FAULT_CUT) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endfunction

  task automatic send_word(logic [7:0] b, logic fin);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_stream.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_stream.valid <= 1'b1;
    in_stream.payload <= in_item_t'{data_byte: b, last_byte: fin};
    do @(posedge clk); while (!in_stream.ready);
    words_sent++;
  endtask

  // The final word of each stream carries the end mark.
  task automatic send_frame();
    int k;
    for (k = 0; k < frame_q.size(); k++) send_word(frame_q[k], k == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Holds the input back until every predicted record has come out.
  task automatic drain();
    in_stream.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // Three records using every mode, the last one completes the stream.
    put_header(3);
    put_record(5, MODE_NEW, 3, 4);
    put_record(0, MODE_SAME, 0, 0);
    put_record(7, MODE_DELTA, zigzag(2), 1);
    send_frame();
    // Empty stream, then an empty stream followed by a stray word.
    put_header(0);
    send_frame();
    put_header(0);
    add_byte(8'hFF);
    send_frame();
    // Wrong first magic word, then a header cut short.
    put_header(1);
    frame_q[0] = 8'h00;
    send_frame();
    put_header(1);
    while (frame_q.size() > 5) void'(frame_q.pop_back());
    send_frame();
    // Header promises a record but the stream ends right after it.
    put_header(1);
    send_frame();
    // Final word completes a record while another one was promised.
    put_header(2);
    put_record(1, MODE_NEW, 1, 1);
    send_frame();
    // Invalid modes, one mid-stream and one on the final word.
    put_header(1);
    put_leb(0, 0);
    add_byte(MODE_DELTA + 8'd1);
    add_byte(8'hFF);
    send_frame();
    put_header(1);
    put_leb(0, 0);
    add_byte(8'hFF);
    send_frame();
    // Varint that keeps going past ten words, mid-stream and on the final word.
    put_header(1);
    repeat (10) add_byte(8'hFF);
    add_byte(8'h00);
    send_frame();
    put_header(1);
    repeat (10) add_byte(8'h80);
    send_frame();
    // Delta that drives the distance to zero, from a set distance and from zero.
    put_header(2);
    put_record(10, MODE_NEW, 5, 1);
    put_record(0, MODE_DELTA, zigzag(-5), 1);
    send_frame();
    put_header(1);
    put_leb(3, 0);
    add_byte(MODE_DELTA);
    put_leb(0, 0);
    send_frame();
    // Out of range: gap, length, distance beyond target, running end past 32 bits.
    put_header(1);
    put_record(64'h1_0000_0000, MODE_SAME, 0, 0);
    send_frame();
    put_header(1);
    put_record(0, MODE_SAME, 0, 64'h1_0000_0000);
    send_frame();
    put_header(1);
    put_record(4, MODE_NEW, 5, 0);
    send_frame();
    put_header(2);
    put_record(LIMIT32, MODE_SAME, 0, 1);
    put_record(0, MODE_SAME, 0, 0);
    send_frame();
    // Largest legal coordinates.
    put_header(1);
    put_record(LIMIT32, MODE_NEW, LIMIT32, LIMIT32);
    send_frame();
    // Words after the last record.
    put_header(1);
    put_record(0, MODE_SAME, 0, 0);
    repeat (3) add_byte(8'($urandom));
    send_frame();
    // End mark on a continuation word.
    put_header(1);
    add_byte(8'h80);
    send_frame();
    // Ten-word gap whose upper bits fall off, and a huge positive delta.
    put_header(1);
    repeat (9) add_byte(8'h80);
    add_byte(8'h7E);
    add_byte(MODE_SAME);
    add_byte(8'h00);
    send_frame();
    put_header(2);
    put_record(1, MODE_NEW, 1, 0);
    put_record(0, MODE_DELTA, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    send_frame();
  endtask

  initial begin
    sb = new();
    in_stream.valid = 1'b0;
    in_stream.payload = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain();
    while (words_sent < 1700) begin
      if (words_sent > 1400) calm = 1'b1;
      build_random_frame();
      send_frame();
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/mrsd_pkg.sv
hdl/mrsd_stream_if.sv
hdl/match_record_stream_decoder.sv
verif/mrsd_check_pkg.sv
verif/tb.sv
